/* design/rcl_pkg.sv */
// ----------------------------------------------------------------------------
// rcl_pkg: shared types and constants for the RIFF chunk locator
// Status codes, header geometry, configuration indexes and result struct.
// ----------------------------------------------------------------------------
`default_nettype none

package rcl_pkg;

  localparam int unsigned HdrIdBytes  = 4;
  localparam int unsigned HdrBytes    = 8;
  localparam int unsigned CfgIdxWidth = 1;

  localparam logic [31:0] TargetIdReset   = 32'd1635017060;
  localparam logic [30:0] RegionSizeReset = 31'd0;

  typedef logic [CfgIdxWidth-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_TARGET_ID   = 1'b0;
  localparam cfg_idx_t CFG_REGION_SIZE = 1'b1;

  typedef logic [1:0] status_t;

  localparam status_t ST_FOUND = 2'd0;
  localparam status_t ST_NONE  = 2'd1;
  localparam status_t ST_ERROR = 2'd2;

  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [31:0] data_offset;
    logic [31:0] chunk_size;
  } result_t;

endpackage

`default_nettype wire

/* design/rcl_cfg.sv */
// ----------------------------------------------------------------------------
// rcl_cfg: configuration registers
// Holds the target chunk ID and the region size written over the config port.
// ----------------------------------------------------------------------------
`default_nettype none

module rcl_cfg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire rcl_pkg::cfg_idx_t cfg_index,
  input  wire logic [31:0]      cfg_data,
  output logic [31:0]           target_id,
  output logic [30:0]           region_size
);
  import rcl_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_id   <= TargetIdReset;
      region_size <= RegionSizeReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TARGET_ID:   target_id   <= cfg_data;
        CFG_REGION_SIZE: region_size <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/rcl_core.sv */
// ----------------------------------------------------------------------------
// rcl_core: chunk header parser and search state
// Consumes one byte per fire, walks headers and payloads, decides on the
// last header byte and produces at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module rcl_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fire,
  input  wire logic [7:0]  data_byte,
  input  wire logic        first,
  input  wire logic [31:0] target_id,
  input  wire logic [30:0] region_size,
  output rcl_pkg::result_t res
);
  import rcl_pkg::*;

  logic        searching, searching_next;
  logic [2:0]  header_phase, header_phase_next;
  logic        id_matches, id_matches_next;
  logic        compare_done, compare_done_next;
  logic [23:0] size_acc, size_acc_next;
  logic [31:0] payload_left, payload_left_next;
  logic [30:0] bytes_remaining, bytes_remaining_next;
  logic [31:0] byte_position, byte_position_next;

  always_comb begin
    logic        s;
    logic [2:0]  ph;
    logic        idm, cdone;
    logic [23:0] acc;
    logic [31:0] pl, pos, size, step;
    logic [30:0] rem;
    logic [7:0]  tb;

    searching_next       = searching;
    header_phase_next    = header_phase;
    id_matches_next      = id_matches;
    compare_done_next    = compare_done;
    size_acc_next        = size_acc;
    payload_left_next    = payload_left;
    bytes_remaining_next = bytes_remaining;
    byte_position_next   = byte_position;
    res                  = '0;

    // a first byte restarts everything
    s     = first ? 1'b1 : searching;
    ph    = first ? 3'd0 : header_phase;
    idm   = first ? 1'b1 : id_matches;
    cdone = first ? 1'b0 : compare_done;
    acc   = first ? 24'd0 : size_acc;
    pl    = first ? 32'd0 : payload_left;
    pos   = first ? 32'd0 : byte_position;
    rem   = first ? region_size : bytes_remaining;
    tb    = target_id[{ph[1:0], 3'b000} +: 8];
    size  = {data_byte, acc};
    step  = size + 32'(HdrBytes);

    if (fire) begin
      if (first) begin
        searching_next       = 1'b1;
        header_phase_next    = 3'd0;
        id_matches_next      = 1'b1;
        compare_done_next    = 1'b0;
        size_acc_next        = '0;
        payload_left_next    = '0;
        byte_position_next   = '0;
        bytes_remaining_next = region_size;
      end
      if (first && region_size == '0) begin
        res.valid      = 1'b1;
        res.status     = ST_NONE;
        searching_next = 1'b0;
      end else if (s) begin
        byte_position_next = pos + 32'd1;
        if (pl != '0) begin
          payload_left_next = pl - 32'd1;
        end else begin
          if (!ph[2]) begin
            if (!cdone) begin
              if (data_byte != tb) begin
                idm   = 1'b0;
                cdone = 1'b1;
              end else if (data_byte == 8'd0) begin
                cdone = 1'b1;
              end
            end
          end else if (ph[1:0] != 2'd3) begin
            acc[{ph[1:0], 3'b000} +: 8] = data_byte;
          end
          if (ph != 3'd7) begin
            header_phase_next = ph + 3'd1;
            id_matches_next   = idm;
            compare_done_next = cdone;
            size_acc_next     = acc;
          end else begin
            // decide on the last header byte
            header_phase_next = 3'd0;
            id_matches_next   = 1'b1;
            compare_done_next = 1'b0;
            size_acc_next     = '0;
            res.chunk_size    = size;
            if (idm) begin
              res.valid       = 1'b1;
              res.status      = ST_FOUND;
              res.data_offset = pos + 32'd1;
              searching_next  = 1'b0;
            end else if (size[31] || step > {1'b0, rem}) begin
              res.valid      = 1'b1;
              res.status     = ST_ERROR;
              searching_next = 1'b0;
            end else begin
              bytes_remaining_next = rem - step[30:0];
              if (rem == step[30:0]) begin
                res.valid      = 1'b1;
                res.status     = ST_NONE;
                searching_next = 1'b0;
              end else begin
                payload_left_next = size;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      searching       <= 1'b0;
      header_phase    <= 3'd0;
      id_matches      <= 1'b1;
      compare_done    <= 1'b0;
      size_acc        <= '0;
      payload_left    <= '0;
      bytes_remaining <= '0;
      byte_position   <= '0;
    end else begin
      searching       <= searching_next;
      header_phase    <= header_phase_next;
      id_matches      <= id_matches_next;
      compare_done    <= compare_done_next;
      size_acc        <= size_acc_next;
      payload_left    <= payload_left_next;
      bytes_remaining <= bytes_remaining_next;
      byte_position   <= byte_position_next;
    end
  end

endmodule

`default_nettype wire

/* design/rcl_out_reg.sv */
// ----------------------------------------------------------------------------
// rcl_out_reg: result register
// Captures a result from the core and holds it while the consumer stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module rcl_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rcl_pkg::result_t res,
  input  wire logic             out_stall,
  output logic                  advance,
  output logic                  out_valid,
  output rcl_pkg::status_t      status,
  output logic [31:0]           data_offset,
  output logic [31:0]           chunk_size
);
  import rcl_pkg::*;

  // hold everything upstream while a result sits unclaimed
  assign advance = !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      status      <= res.status;
      data_offset <= res.data_offset;
      chunk_size  <= res.chunk_size;
    end
  end

endmodule

`default_nettype wire

/* design/riff_chunk_locator_top.sv */
// ----------------------------------------------------------------------------
// riff_chunk_locator_top: RIFF chunk search over a byte stream
// Finds the chunk whose ID matches target_id and reports its data offset.
// ----------------------------------------------------------------------------
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | data_byte, first
//   out     | output    | out_valid/out_stall| status, data_offset, chunk_size
//   cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One byte per cycle sustained while no result is held by out_stall: input
// register, header/skip logic in the core, result register. out_valid comes
// from the result register, which the core feeds from the input register.
// Synchronous reset clears the search state and reloads the config defaults.
// A stalled result freezes the core and the input register; one more item
// is still taken into the input register while the result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module riff_chunk_locator_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        data_byte,
  input  wire logic              first,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rcl_pkg::status_t       status,
  output logic [31:0]            data_offset,
  output logic signed [31:0]     chunk_size,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire rcl_pkg::cfg_idx_t cfg_index,
  input  wire logic [31:0]       cfg_data
);
  import rcl_pkg::*;

  logic        in_q_valid;
  logic [7:0]  in_q_byte;
  logic        in_q_first;
  logic        advance;
  logic        fire;
  logic [31:0] target_id;
  logic [30:0] region_size;
  logic [31:0] size_raw;
  result_t     res;

  assign in_stall = in_q_valid && !advance;
  assign fire     = in_q_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q_byte  <= data_byte;
      in_q_first <= first;
    end
  end

  rcl_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .target_id   (target_id),
    .region_size (region_size)
  );

  rcl_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .data_byte   (in_q_byte),
    .first       (in_q_first),
    .target_id   (target_id),
    .region_size (region_size),
    .res         (res)
  );

  rcl_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .res         (res),
    .out_stall   (out_stall),
    .advance     (advance),
    .out_valid   (out_valid),
    .status      (status),
    .data_offset (data_offset),
    .chunk_size  (size_raw)
  );

  assign chunk_size = $signed(size_raw);

endmodule

`default_nettype wire
